// File: rtl/bde_pkg.sv
// Shared types and constants for the button debounce event queue.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package bde_pkg;

	// Request kinds carried on the request channel
	typedef enum logic {
		REQ_POLL = 1'b0,
		REQ_POP  = 1'b1
	} req_kind_t;

	localparam int unsigned STAMP_W = 32;
	localparam int unsigned COUNT_W = 16;

	// Debounce threshold after reset
	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd10;

endpackage

// File: rtl/bde_if.sv
// Valid/ready channel interfaces for the request and event sides.
// Depends on bde_pkg for the time stamp width.
interface bde_req_if #(
	parameter int unsigned BUTTONS = 2
);
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [BUTTONS-1:0]          button_levels;
	logic [bde_pkg::STAMP_W-1:0] now_ms;

	modport source (output valid, req_type, button_levels, now_ms, input ready);
	modport sink (input valid, req_type, button_levels, now_ms, output ready);
endinterface

interface bde_evt_if #(
	parameter int unsigned IDX_W  = 1,
	parameter int unsigned PEND_W = 4
);
	logic                        valid;
	logic                        ready;
	logic                        event_valid;
	logic [IDX_W-1:0]            event_button;
	logic [bde_pkg::STAMP_W-1:0] press_duration;
	logic [PEND_W-1:0]           events_pending;

	modport source (output valid, event_valid, event_button, press_duration, events_pending,
		input ready);
	modport sink (input valid, event_valid, event_button, press_duration, events_pending,
		output ready);
endinterface

// File: rtl/bde_debounce.sv
// Per-button debounce counters, pressed flags and press stamps.
// Depends on bde_pkg; instantiated by button_debounce_event_queue.
module bde_debounce #(
	parameter int unsigned BUTTONS = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        poll_en,
	input  logic [BUTTONS-1:0]          levels,
	input  logic [bde_pkg::STAMP_W-1:0] now_ms,
	input  logic [bde_pkg::COUNT_W-1:0] debounce_count,
	output logic [BUTTONS-1:0]          release_hit,
	output logic [bde_pkg::STAMP_W-1:0] duration [BUTTONS]
);

	for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
		logic                        pressed_q;
		logic [bde_pkg::COUNT_W-1:0] count_q;
		logic [bde_pkg::STAMP_W-1:0] stamp_q;
		logic                        differs;
		logic [bde_pkg::COUNT_W:0]   count_inc;
		logic                        settled;

		// A released button waits for low samples, a pressed one for high
		assign differs   = pressed_q ? levels[i] : ~levels[i];
		assign count_inc = {1'b0, count_q} + 1'b1;
		assign settled   = differs && (count_inc >= {1'b0, debounce_count});

		assign release_hit[i] = poll_en && settled && pressed_q;
		assign duration[i]    = now_ms - stamp_q;

		// Advance the counter, toggle the state once it has settled
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pressed_q <= 1'b0;
				count_q   <= '0;
				stamp_q   <= '0;
			end else if (poll_en) begin
				if (!differs) begin
					count_q <= '0;
				end else if (settled) begin
					count_q   <= '0;
					pressed_q <= ~pressed_q;
					if (!pressed_q) begin
						stamp_q <= now_ms;
					end
				end else begin
					count_q <= count_inc[bde_pkg::COUNT_W-1:0];
				end
			end
		end
	end

endmodule

// File: rtl/bde_queue.sv
// Ring buffer of release events with several pushes or one pop per step.
// Depends on bde_pkg; instantiated by button_debounce_event_queue.
module bde_queue #(
	parameter int unsigned BUTTONS     = 2,
	parameter int unsigned QUEUE_DEPTH = 8,
	parameter int unsigned IDX_W       = 1,
	parameter int unsigned PEND_W      = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic                        pop_req,
	input  logic [BUTTONS-1:0]          release_hit,
	input  logic [bde_pkg::STAMP_W-1:0] duration [BUTTONS],
	output logic                        event_valid,
	output logic [IDX_W-1:0]            event_button,
	output logic [bde_pkg::STAMP_W-1:0] press_duration,
	output logic [PEND_W-1:0]           events_pending
);

	localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned ENTRY_W = IDX_W + bde_pkg::STAMP_W;

	logic [ENTRY_W-1:0] store [QUEUE_DEPTH];
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q, rd_ptr_n, wr_ptr_n;
	logic [PEND_W-1:0]  count_q, count_n;
	logic [BUTTONS-1:0] wr_en;
	logic [PTR_W-1:0]   wr_slot [BUTTONS];
	logic               pop_hit;
	logic               ev_valid_q;
	logic [ENTRY_W-1:0] rd_data_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pop_hit = pop_req && (count_q != '0);

	// Place releases in button order into consecutive slots, drop when full
	always_comb begin
		wr_ptr_n = wr_ptr_q;
		rd_ptr_n = rd_ptr_q;
		count_n  = count_q;
		wr_en    = '0;
		for (int i = 0; i < BUTTONS; i++) begin
			wr_slot[i] = wr_ptr_n;
			if (!pop_req && release_hit[i] && (count_n < PEND_W'(QUEUE_DEPTH))) begin
				wr_en[i] = 1'b1;
				wr_ptr_n = ptr_next(wr_ptr_n);
				count_n  = count_n + 1'b1;
			end
		end
		if (pop_hit) begin
			rd_ptr_n = ptr_next(rd_ptr_q);
			count_n  = count_q - 1'b1;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			count_q    <= '0;
			ev_valid_q <= 1'b0;
		end else if (step_en) begin
			rd_ptr_q   <= rd_ptr_n;
			wr_ptr_q   <= wr_ptr_n;
			count_q    <= count_n;
			ev_valid_q <= pop_hit;
		end
	end

	// Store writes and registered read of the oldest entry
	always_ff @(posedge clk) begin
		if (step_en) begin
			for (int i = 0; i < BUTTONS; i++) begin
				if (wr_en[i]) begin
					store[wr_slot[i]] <= {IDX_W'(i), duration[i]};
				end
			end
			rd_data_q <= pop_hit ? store[rd_ptr_q] : '0;
		end
	end

	assign event_valid    = ev_valid_q;
	assign event_button   = rd_data_q[ENTRY_W-1 -: IDX_W];
	assign press_duration = rd_data_q[bde_pkg::STAMP_W-1:0];
	assign events_pending = count_q;

endmodule

// File: rtl/button_debounce_event_queue.sv
// Top level: debounces active-low buttons and queues release events.
// Depends on bde_pkg, bde_if, bde_debounce and bde_queue.
//
// Usage:
//   req channel: each transaction is a poll (req_type 0) carrying one sample of
//   button_levels with its now_ms stamp, or a pop (req_type 1) of the oldest
//   queued release event. Every request gives exactly one evt transaction:
//   event_valid, event_button, press_duration and the queue fill level after
//   the request. A pop on an empty queue returns event_valid 0 with zeros.
//   cfg_wr_en / cfg_wr_data set the debounce threshold; write while idle only.
// Timing:
//   A request is registered on acceptance in the input register and then loads
//   the result register when evt is not stalled. One request is accepted every
//   cycle while evt is not stalled; the per-button counters and the ring buffer
//   pointers update together as each request steps through.
// Reset and stall:
//   arst_n clears buttons to released, counters, stamps and the queue pointers,
//   and sets the threshold to 10. While evt is stalled the result holds and the
//   input register takes one more request before req.ready drops.
module button_debounce_event_queue #(
	parameter int unsigned BUTTONS     = 2,
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bde_pkg::COUNT_W-1:0] cfg_wr_data,
	bde_req_if.sink                     req,
	bde_evt_if.source                   evt
);

	localparam int unsigned IDX_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int unsigned PEND_W = $clog2(QUEUE_DEPTH + 1);

	logic [bde_pkg::COUNT_W-1:0] debounce_count_q;
	logic                        valid_s1;
	logic                        req_type_s1;
	logic [BUTTONS-1:0]          levels_s1;
	logic [bde_pkg::STAMP_W-1:0] now_s1;
	logic                        evt_valid_q;
	logic                        advance;
	logic                        step_en;
	logic                        poll_en;
	logic                        pop_req;
	logic [BUTTONS-1:0]          release_hit;
	logic [bde_pkg::STAMP_W-1:0] duration [BUTTONS];

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_count_q <= bde_pkg::DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			debounce_count_q <= cfg_wr_data;
		end
	end

	// Advance whenever the result register is free or being taken
	assign advance   = !evt_valid_q || evt.ready;
	assign req.ready = !valid_s1 || advance;
	assign step_en   = valid_s1 && advance;
	assign pop_req   = (req_type_s1 == bde_pkg::REQ_POP);
	assign poll_en   = step_en && !pop_req;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			levels_s1   <= req.button_levels;
			now_s1      <= req.now_ms;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (advance) begin
			evt_valid_q <= valid_s1;
		end
	end

	bde_debounce #(
		.BUTTONS(BUTTONS)
	) u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.poll_en       (poll_en),
		.levels        (levels_s1),
		.now_ms        (now_s1),
		.debounce_count(debounce_count_q),
		.release_hit   (release_hit),
		.duration      (duration)
	);

	bde_queue #(
		.BUTTONS    (BUTTONS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IDX_W      (IDX_W),
		.PEND_W     (PEND_W)
	) u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.pop_req       (pop_req),
		.release_hit   (release_hit),
		.duration      (duration),
		.event_valid   (evt.event_valid),
		.event_button  (evt.event_button),
		.press_duration(evt.press_duration),
		.events_pending(evt.events_pending)
	);

	assign evt.valid = evt_valid_q;

	// Fill level never exceeds the ring size
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> (evt.events_pending <= PEND_W'(QUEUE_DEPTH)))
		else $error("event queue fill level above depth");

	// A result without an event carries zero payload
	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && !evt.event_valid) |->
			(evt.event_button == '0 && evt.press_duration == '0))
		else $error("payload set on a result without an event");

	// An empty result register always lets a request in
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.valid |-> req.ready)
		else $error("request channel blocked with empty result register");

	// A stalled result holds its payload until taken
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && !evt.ready) |=>
			(evt.valid && $stable(evt.event_valid) && $stable(evt.event_button) &&
			$stable(evt.press_duration) && $stable(evt.events_pending)))
		else $error("stalled event transaction changed");

endmodule
